FILE: hdl/ssq_pkg.sv
`timescale 1ns / 1ps

package ssq_pkg;

	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_PEEK   = 2'd1;
	localparam logic [1:0] REQ_REMOVE = 2'd2;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	typedef struct packed {
		logic       do_insert;
		logic       do_remove;
		logic       emit;
		logic       zero_head;
		logic [1:0] status;
	} ssq_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} ssq_stat_t;

endpackage

FILE: hdl/ssq_ctrl.sv
`timescale 1ns / 1ps

module ssq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [1:0]        req_type,
	input  ssq_pkg::ssq_stat_t stat,
	output ssq_pkg::ssq_cmd_t  cmd,
	output logic              busy,
	output logic              done
);
	import ssq_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RESP = 1'b1;

	logic state_q;
	logic accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign done   = (state_q == ST_RESP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= accept ? ST_RESP : ST_IDLE;
		end
	end

	always_comb begin
		cmd           = '0;
		cmd.emit      = accept;
		cmd.status    = STAT_OK;
		case (req_type)
			REQ_INSERT: begin
				if (stat.full) begin
					cmd.status = STAT_FULL;
				end else begin
					cmd.do_insert = accept;
				end
			end
			REQ_REMOVE: begin
				if (stat.empty) begin
					cmd.status    = STAT_EMPTY;
					cmd.zero_head = 1'b1;
				end else begin
					cmd.do_remove = accept;
				end
			end
			default: begin
				if (stat.empty) begin
					cmd.status    = STAT_EMPTY;
					cmd.zero_head = 1'b1;
				end
			end
		endcase
	end

endmodule

FILE: hdl/ssq_datapath.sv
`timescale 1ns / 1ps

module ssq_datapath #(
	parameter int DEPTH     = 16,
	parameter int TAG_BITS  = 16,
	parameter int PRIO_BITS = 3,
	localparam int CNT_BITS = $clog2(DEPTH + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ssq_pkg::ssq_cmd_t    cmd,
	input  logic [PRIO_BITS-1:0] item_priority,
	input  logic [TAG_BITS-1:0]  item_tag,
	output ssq_pkg::ssq_stat_t   stat,
	output logic                 head_valid,
	output logic [PRIO_BITS-1:0] head_priority,
	output logic [TAG_BITS-1:0]  head_tag,
	output logic [1:0]           status,
	output logic [CNT_BITS-1:0]  fill_count
);
	import ssq_pkg::*;

	logic [PRIO_BITS-1:0] slot_prio_q [DEPTH];
	logic [TAG_BITS-1:0]  slot_tag_q  [DEPTH];
	logic [CNT_BITS-1:0]  count_q;
	logic [CNT_BITS-1:0]  count_d;

	logic [DEPTH-1:0]     le;
	logic [DEPTH-1:0]     ins_here;
	logic [PRIO_BITS-1:0] prev_prio [DEPTH];
	logic [TAG_BITS-1:0]  prev_tag  [DEPTH];
	logic [PRIO_BITS-1:0] next_prio [DEPTH];
	logic [TAG_BITS-1:0]  next_tag  [DEPTH];

	logic                 head_valid_q;
	logic [PRIO_BITS-1:0] head_prio_q;
	logic [TAG_BITS-1:0]  head_tag_q;
	logic [1:0]           status_q;
	logic [CNT_BITS-1:0]  fill_q;

	assign stat.full  = (count_q == CNT_BITS'(DEPTH));
	assign stat.empty = (count_q == '0);

	for (genvar i = 0; i < DEPTH; i++) begin : g_slot
		assign le[i] = (CNT_BITS'(i) < count_q) && (slot_prio_q[i] <= item_priority);

		if (i == 0) begin : g_first
			assign ins_here[i] = !le[i];
			assign prev_prio[i] = item_priority;
			assign prev_tag[i]  = item_tag;
		end else begin : g_rest
			assign ins_here[i] = !le[i] && le[i-1];
			assign prev_prio[i] = ins_here[i] ? item_priority : slot_prio_q[i-1];
			assign prev_tag[i]  = ins_here[i] ? item_tag : slot_tag_q[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign next_prio[i] = slot_prio_q[i];
			assign next_tag[i]  = slot_tag_q[i];
		end else begin : g_mid
			assign next_prio[i] = slot_prio_q[i+1];
			assign next_tag[i]  = slot_tag_q[i+1];
		end

		always_ff @(posedge clk) begin
			if (cmd.do_insert && !le[i]) begin
				slot_prio_q[i] <= prev_prio[i];
				slot_tag_q[i]  <= prev_tag[i];
			end else if (cmd.do_remove) begin
				slot_prio_q[i] <= next_prio[i];
				slot_tag_q[i]  <= next_tag[i];
			end
		end
	end

	always_comb begin
		count_d = count_q;
		if (cmd.do_insert) begin
			count_d = count_q + 1'b1;
		end else if (cmd.do_remove) begin
			count_d = count_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			status_q     <= cmd.status;
			fill_q       <= count_d;
			head_valid_q <= !cmd.zero_head;
			if (cmd.zero_head) begin
				head_prio_q <= '0;
				head_tag_q  <= '0;
			end else if (cmd.do_insert && ins_here[0]) begin
				head_prio_q <= item_priority;
				head_tag_q  <= item_tag;
			end else begin
				head_prio_q <= slot_prio_q[0];
				head_tag_q  <= slot_tag_q[0];
			end
		end
	end

	assign head_valid    = head_valid_q;
	assign head_priority = head_prio_q;
	assign head_tag      = head_tag_q;
	assign status        = status_q;
	assign fill_count    = fill_q;

endmodule

FILE: hdl/stable_sorted_priority_queue.sv
`timescale 1ns / 1ps
// channel   direction  handshake          payload
// request   in         start & !busy      req_type, item_priority, item_tag
// result    out        done (one cycle)   head_valid, head_priority, head_tag, status, fill_count
//
// one request per cycle; busy stays low
// the result shows on the cycle after the request, for one cycle, flagged by done
// insert position comes from a combinational per-slot compare over the shift-register slots
// arst_n clears the entry count and done; slots and result outputs stay unknown until written
// the receiver cannot stall, so a result is never held back

module stable_sorted_priority_queue #(
	parameter int DEPTH     = 16,
	parameter int TAG_BITS  = 16,
	parameter int PRIO_BITS = 3,
	localparam int CNT_BITS = $clog2(DEPTH + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           req_type,
	input  logic [PRIO_BITS-1:0] item_priority,
	input  logic [TAG_BITS-1:0]  item_tag,
	output logic                 done,
	output logic                 head_valid,
	output logic [PRIO_BITS-1:0] head_priority,
	output logic [TAG_BITS-1:0]  head_tag,
	output logic [1:0]           status,
	output logic [CNT_BITS-1:0]  fill_count
);
	import ssq_pkg::*;

	ssq_cmd_t  cmd;
	ssq_stat_t stat;

	ssq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.stat     (stat),
		.cmd      (cmd),
		.busy     (busy),
		.done     (done)
	);

	ssq_datapath #(
		.DEPTH     (DEPTH),
		.TAG_BITS  (TAG_BITS),
		.PRIO_BITS (PRIO_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.item_priority (item_priority),
		.item_tag      (item_tag),
		.stat          (stat),
		.head_valid    (head_valid),
		.head_priority (head_priority),
		.head_tag      (head_tag),
		.status        (status),
		.fill_count    (fill_count)
	);

endmodule

FILE: tb/stable_sorted_priority_queue_tb.sv
`timescale 1ns / 1ps

module stable_sorted_priority_queue_tb;
	import ssq_pkg::*;

	localparam int QUEUE_DEPTH = 16;
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int RANDOM_REQUESTS = 1500;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		logic [2:0]  prio;
		logic [15:0] tag;
	} slot_t;

	typedef struct {
		logic        valid;
		logic [2:0]  prio;
		logic [15:0] tag;
		logic [1:0]  status;
		logic [4:0]  fill;
	} head_report_t;

	class queue_scoreboard;
		slot_t        stored[$];
		head_report_t predicted[$];
		int           mismatches;
		int           inserts;
		int           removes;
		int           full_drops;
		int           empty_hits;
		int           checked;

		function int pending();
			return predicted.size();
		endfunction

		// sorted insert keeps equal priorities in arrival order
		function void note_request(logic [1:0] req, logic [2:0] prio, logic [15:0] tag);
			head_report_t r;
			slot_t        s;
			int           pos;
			r = '{default: '0};
			if (req == REQ_INSERT) begin
				inserts++;
				if (stored.size() >= QUEUE_DEPTH) begin
					r.status = STAT_FULL;
					full_drops++;
				end else begin
					pos = 0;
					while (pos < stored.size() && stored[pos].prio <= prio)
						pos++;
					s.prio = prio;
					s.tag = tag;
					stored.insert(pos, s);
					r.status = STAT_OK;
				end
				r.valid = 1'b1;
				r.prio = stored[0].prio;
				r.tag = stored[0].tag;
			end else if (stored.size() == 0) begin
				r.status = STAT_EMPTY;
				empty_hits++;
			end else begin
				r.valid = 1'b1;
				r.prio = stored[0].prio;
				r.tag = stored[0].tag;
				r.status = STAT_OK;
				if (req == REQ_REMOVE) begin
					void'(stored.pop_front());
					removes++;
				end
			end
			r.fill = 5'(stored.size());
			predicted.push_back(r);
		endfunction

		function void check_result(head_report_t got);
			head_report_t exp;
			if (predicted.size() == 0) begin
				$error("result strobe with no request outstanding");
				mismatches++;
				return;
			end
			exp = predicted.pop_front();
			checked++;
			if (got.valid !== exp.valid) begin
				$error("head_valid: expected %0d, got %0d", exp.valid, got.valid);
				mismatches++;
			end
			if (got.prio !== exp.prio) begin
				$error("head_priority: expected %0d, got %0d", exp.prio, got.prio);
				mismatches++;
			end
			if (got.tag !== exp.tag) begin
				$error("head_tag: expected %h, got %h", exp.tag, got.tag);
				mismatches++;
			end
			if (got.status !== exp.status) begin
				$error("status: expected %0d, got %0d", exp.status, got.status);
				mismatches++;
			end
			if (got.fill !== exp.fill) begin
				$error("fill_count: expected %0d, got %0d", exp.fill, got.fill);
				mismatches++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  req_type;
	logic [2:0]  item_priority;
	logic [15:0] item_tag;
	logic        done;
	logic        head_valid;
	logic [2:0]  head_priority;
	logic [15:0] head_tag;
	logic [1:0]  status;
	logic [4:0]  fill_count;

	queue_scoreboard sb = new();
	bit steady;

	stable_sorted_priority_queue #(
		.DEPTH(QUEUE_DEPTH),
		.TAG_BITS(16),
		.PRIO_BITS(3)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.item_priority(item_priority),
		.item_tag(item_tag),
		.done(done),
		.head_valid(head_valid),
		.head_priority(head_priority),
		.head_tag(head_tag),
		.status(status),
		.fill_count(fill_count)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("CHECK FAILED");
		$finish;
	end

	always @(posedge clk) begin
		head_report_t got;
		if (arst_n) begin
			if (done === 1'b1) begin
				got.valid = head_valid;
				got.prio = head_priority;
				got.tag = head_tag;
				got.status = status;
				got.fill = fill_count;
				sb.check_result(got);
			end
			if (start && busy === 1'b0)
				sb.note_request(req_type, item_priority, item_tag);
		end
	end

	task automatic gap();
		int n;
		n = 0;
		if (!steady)
			while ($urandom_range(0, 99) < 37)
				n++;
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_request(logic [1:0] req, logic [2:0] prio, logic [15:0] tag);
		gap();
		start <= 1'b1;
		req_type <= req;
		item_priority <= prio;
		item_tag <= tag;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		@(negedge clk);
		while (sb.pending() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	initial begin
		logic [2:0] fill_prio[16];
		logic [1:0] req;
		logic [2:0] prio;
		int         mode;
		int         pick;
		int         ins_weight;
		int         rem_weight;

		fill_prio = '{3'd7, 3'd0, 3'd3, 3'd3, 3'd7, 3'd0, 3'd5, 3'd3,
			3'd1, 3'd7, 3'd0, 3'd6, 3'd2, 3'd3, 3'd4, 3'd0};
		arst_n <= 1'b0;
		start <= 1'b0;
		req_type <= REQ_INSERT;
		item_priority <= '0;
		item_tag <= '0;
		steady = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue, including the unused code
		send_request(REQ_PEEK, 3'd7, 16'hFFFF);
		send_request(REQ_REMOVE, 3'd0, 16'h0000);
		send_request(REQ_UNUSED, 3'd5, 16'h1234);
		// fill to the brim with repeated priorities and extreme tags
		for (int i = 0; i < QUEUE_DEPTH; i++)
			send_request(REQ_INSERT, fill_prio[i],
				(i == 0) ? 16'hFFFF : (i == 1) ? 16'h0000 : 16'(16'h0A00 + i));
		send_request(REQ_INSERT, 3'd0, 16'hBEEF);
		send_request(REQ_PEEK, 3'd0, 16'h0000);
		send_request(REQ_UNUSED, 3'd2, 16'h5555);
		repeat (3) send_request(REQ_REMOVE, 3'd7, 16'hAAAA);
		wait_drained();

		mode = 0;
		for (int k = 0; k < RANDOM_REQUESTS; k++) begin
			if (k % 40 == 0)
				mode = $urandom_range(0, 3);
			steady = (k >= 600 && k < 900);
			if (k == 1000)
				wait_drained();
			// burst modes push the queue toward full or empty
			ins_weight = (mode == 1) ? 75 : (mode == 2) ? 20 : 45;
			rem_weight = (mode == 1) ? 15 : (mode == 2) ? 70 : 40;
			pick = $urandom_range(0, 99);
			if (pick < ins_weight)
				req = REQ_INSERT;
			else if (pick < ins_weight + rem_weight)
				req = REQ_REMOVE;
			else
				req = ($urandom_range(0, 3) == 0) ? REQ_UNUSED : REQ_PEEK;
			prio = (mode == 3) ? 3'($urandom_range(0, 1)) : 3'($urandom_range(0, 7));
			send_request(req, prio, 16'($urandom_range(0, 65535)));
		end

		start <= 1'b0;
		@(negedge clk);
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);

		$display("%0d results checked: %0d inserts (%0d dropped on full), %0d removes,",
			sb.checked, sb.inserts, sb.full_drops, sb.removes);
		$display("%0d requests met an empty queue", sb.empty_hits);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: sim.f
hdl/ssq_pkg.sv
hdl/ssq_ctrl.sv
hdl/ssq_datapath.sv
hdl/stable_sorted_priority_queue.sv
tb/stable_sorted_priority_queue_tb.sv
